>>> sv/anchor_box_decode_top_macros.svh
// Assertion macros for the anchor box decoder.
// Used by anchor_box_decode_top; expects i_clk and i_rst_n in scope.
`ifndef ANCHOR_BOX_DECODE_TOP_MACROS_SVH
`define ANCHOR_BOX_DECODE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define ABD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ABD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/abd_pkg.sv
// Shared types, constants and helpers for the anchor box decoder.
// No dependencies.
package abd_pkg;

    // pipeline stage numbers
    localparam int ST_MUL   = 1;
    localparam int ST_CLAMP = 2;
    localparam int ST_QUOT  = 3;
    localparam int ST_REM   = 4;
    localparam int ST_HORN  = 5;
    localparam int H_STEPS  = 8;
    localparam int ST_PROD  = ST_HORN + 2 * H_STEPS;
    localparam int ST_HALF  = ST_PROD + 1;
    localparam int ST_OUT   = ST_HALF + 1;
    localparam int N_STG    = ST_OUT;

    typedef logic [N_STG:1] t_stg_en;

    typedef enum logic [1:0] {
        CFG_Y_RECIP = 2'd0,
        CFG_X_RECIP = 2'd1,
        CFG_H_RECIP = 2'd2,
        CFG_W_RECIP = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] Y_RECIP_RST = 16'd1638;
    localparam logic [15:0] X_RECIP_RST = 16'd1638;
    localparam logic [15:0] H_RECIP_RST = 16'd3277;
    localparam logic [15:0] W_RECIP_RST = 16'd3277;

    // Q.26 fixed point for the exp unit
    localparam int FRAC_S = 26;
    localparam logic [27:0] ONE_S = 28'd1 << FRAC_S;
    localparam logic [30:0] LN2_S = 31'd46516320;
    localparam logic signed [31:0] ARG_MIN = -32'sd805306368;
    localparam logic signed [31:0] ARG_MAX = 32'sd268435456;
    localparam logic signed [31:0] V_BIAS  = 32'sd837293760;

    // exact floor(v / LN2) for v < 2^31 via reciprocal multiply
    localparam int Q_SHIFT = 57;
    localparam logic [31:0] Q_MAGIC =
        32'(((64'd1 << Q_SHIFT) + 64'd46516319) / 64'd46516320);

    // exact floor(x / n) for x < 2^28 is (x * horner_magic(n)) >> DIV_SHIFT
    localparam int DIV_SHIFT = 31;

    // prod >> (HALF_SH_BASE - q) gives twice the half extent before rounding
    localparam int HALF_SH_BASE = 44;

    // centre rounding offset, Q.40 -> Q.14
    localparam logic signed [47:0] CEN_HALF = 48'sd33554432;

    localparam logic signed [23:0] OUT_MIN = -24'sd524288;
    localparam logic signed [23:0] OUT_MAX = 24'sd524287;

    function automatic logic [31:0] horner_magic(input int n);
        logic [31:0] m;
        case (n)
            1:       m = 32'h8000_0000;
            2:       m = 32'h4000_0000;
            3:       m = 32'd715827883;
            4:       m = 32'h2000_0000;
            5:       m = 32'd429496730;
            6:       m = 32'd357913942;
            7:       m = 32'd306783379;
            8:       m = 32'h1000_0000;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic signed [19:0] sat_out(input logic signed [23:0] v);
        logic signed [19:0] s;
        if (v < OUT_MIN) begin
            s = OUT_MIN[19:0];
        end else if (v > OUT_MAX) begin
            s = OUT_MAX[19:0];
        end else begin
            s = v[19:0];
        end
        return s;
    endfunction

endpackage

>>> sv/abd_in_if.sv
// Request channel of the anchor box decoder: one encoding plus its anchor.
// No dependencies.
interface abd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] enc_y;
    logic signed [15:0] enc_x;
    logic signed [15:0] enc_h;
    logic signed [15:0] enc_w;
    logic signed [15:0] anchor_y;
    logic signed [15:0] anchor_x;
    logic [14:0]        anchor_h;
    logic [14:0]        anchor_w;

    modport source (
        output valid, enc_y, enc_x, enc_h, enc_w,
        output anchor_y, anchor_x, anchor_h, anchor_w,
        input  ready
    );
    modport sink (
        input  valid, enc_y, enc_x, enc_h, enc_w,
        input  anchor_y, anchor_x, anchor_h, anchor_w,
        output ready
    );
endinterface

>>> sv/abd_out_if.sv
// Result channel of the anchor box decoder: box corners, signed Q5.14.
// No dependencies.
interface abd_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] box_ymin;
    logic signed [19:0] box_xmin;
    logic signed [19:0] box_ymax;
    logic signed [19:0] box_xmax;

    modport source (
        output valid, box_ymin, box_xmin, box_ymax, box_xmax,
        input  ready
    );
    modport sink (
        input  valid, box_ymin, box_xmin, box_ymax, box_xmax,
        output ready
    );
endinterface

>>> sv/anchor_box_decode_top.sv
// Anchor box decoder top level: config registers, centre path, corners.
// Depends on abd_pkg, abd_in_if, abd_out_if, abd_exp_half and the macro header.
//
//  channel   dir  handshake            payload
//  i_req     in   valid / ready        enc_y/x/h/w, anchor_y/x/h/w
//  o_rsp     out  valid / ready        box_ymin/xmin/ymax/xmax
//  i_cfg_*   in   write enable only    index (2 bits), data (16 bits)
//
// One request per cycle while o_rsp is not stalled, through the 23-stage pipeline
// with its eight Horner multiply and divide stage pairs.
// Reset clears all stage valid bits and loads the default reciprocals.
// A stage holds while it and every stage after it are full and o_rsp is
// stalled; empty stages keep filling, so requests are taken during stalls.
`include "anchor_box_decode_top_macros.svh"

module anchor_box_decode_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abd_in_if.sink      i_req,
    abd_out_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_y_recip;
    logic [15:0] r_x_recip;
    logic [15:0] r_h_recip;
    logic [15:0] r_w_recip;

    abd_pkg::t_stg_en   w_en;
    abd_pkg::t_stg_en   r_vld;

    logic signed [32:0] w_sy, w_sx, w_th, w_tw;
    logic signed [31:0] r_sy, r_sx, r_th, r_tw;
    logic signed [15:0] r_ay1, r_ax1, r_ay2, r_ax2;
    logic [14:0]        r_ah1, r_aw1;
    logic signed [47:0] r_pcy, r_pcx;
    logic signed [47:0] w_rcy, w_rcx;
    logic signed [22:0] r_cy [abd_pkg::ST_QUOT:abd_pkg::ST_HALF];
    logic signed [22:0] r_cx [abd_pkg::ST_QUOT:abd_pkg::ST_HALF];
    logic [21:0]        w_hh, w_hw;
    logic signed [23:0] w_ymin, w_xmin, w_ymax, w_xmax;
    logic signed [19:0] r_ymin, r_xmin, r_ymax, r_xmax;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_recip <= abd_pkg::Y_RECIP_RST;
            r_x_recip <= abd_pkg::X_RECIP_RST;
            r_h_recip <= abd_pkg::H_RECIP_RST;
            r_w_recip <= abd_pkg::W_RECIP_RST;
        end else if (i_cfg_we) begin
            unique case (abd_pkg::t_cfg_idx'(i_cfg_idx))
                abd_pkg::CFG_Y_RECIP: r_y_recip <= i_cfg_data;
                abd_pkg::CFG_X_RECIP: r_x_recip <= i_cfg_data;
                abd_pkg::CFG_H_RECIP: r_h_recip <= i_cfg_data;
                abd_pkg::CFG_W_RECIP: r_w_recip <= i_cfg_data;
            endcase
        end
    end

    // stage k advances unless it and all later stages are full and output stalls
    for (genvar k = 1; k <= abd_pkg::N_STG; k++) begin : g_en
        assign w_en[k] = o_rsp.ready | ~(&r_vld[abd_pkg::N_STG:k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[abd_pkg::ST_MUL]) begin
                r_vld[abd_pkg::ST_MUL] <= i_req.valid;
            end
            for (int k = abd_pkg::ST_MUL + 1; k <= abd_pkg::N_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_req.ready = w_en[abd_pkg::ST_MUL];

    // stage 1: offsets times reciprocals
    assign w_sy = 33'(i_req.enc_y) * 33'($signed({1'b0, r_y_recip}));
    assign w_sx = 33'(i_req.enc_x) * 33'($signed({1'b0, r_x_recip}));
    assign w_th = 33'(i_req.enc_h) * 33'($signed({1'b0, r_h_recip}));
    assign w_tw = 33'(i_req.enc_w) * 33'($signed({1'b0, r_w_recip}));

    // stage 3: round to nearest, ties away from zero
    assign w_rcy = r_pcy + abd_pkg::CEN_HALF - $signed({47'd0, r_pcy[47]});
    assign w_rcx = r_pcx + abd_pkg::CEN_HALF - $signed({47'd0, r_pcx[47]});

    always_ff @(posedge i_clk) begin
        if (w_en[abd_pkg::ST_MUL]) begin
            r_sy  <= w_sy[31:0];
            r_sx  <= w_sx[31:0];
            r_th  <= w_th[31:0];
            r_tw  <= w_tw[31:0];
            r_ay1 <= i_req.anchor_y;
            r_ax1 <= i_req.anchor_x;
            r_ah1 <= i_req.anchor_h;
            r_aw1 <= i_req.anchor_w;
        end
        if (w_en[abd_pkg::ST_CLAMP]) begin
            r_pcy <= 48'(r_sy) * 48'($signed({1'b0, r_ah1}));
            r_pcx <= 48'(r_sx) * 48'($signed({1'b0, r_aw1}));
            r_ay2 <= r_ay1;
            r_ax2 <= r_ax1;
        end
        if (w_en[abd_pkg::ST_QUOT]) begin
            r_cy[abd_pkg::ST_QUOT] <= 23'($signed(w_rcy[47:26])) + 23'(r_ay2);
            r_cx[abd_pkg::ST_QUOT] <= 23'($signed(w_rcx[47:26])) + 23'(r_ax2);
        end
        for (int k = abd_pkg::ST_QUOT + 1; k <= abd_pkg::ST_HALF; k++) begin
            if (w_en[k]) begin
                r_cy[k] <= r_cy[k-1];
                r_cx[k] <= r_cx[k-1];
            end
        end
    end

    abd_exp_half u_exp_h (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_arg  (r_th),
        .i_size (r_ah1),
        .o_half (w_hh)
    );

    abd_exp_half u_exp_w (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_arg  (r_tw),
        .i_size (r_aw1),
        .o_half (w_hw)
    );

    // output stage: corners with saturation
    assign w_ymin = 24'(r_cy[abd_pkg::ST_HALF]) - $signed({2'b00, w_hh});
    assign w_ymax = 24'(r_cy[abd_pkg::ST_HALF]) + $signed({2'b00, w_hh});
    assign w_xmin = 24'(r_cx[abd_pkg::ST_HALF]) - $signed({2'b00, w_hw});
    assign w_xmax = 24'(r_cx[abd_pkg::ST_HALF]) + $signed({2'b00, w_hw});

    always_ff @(posedge i_clk) begin
        if (w_en[abd_pkg::ST_OUT]) begin
            r_ymin <= abd_pkg::sat_out(w_ymin);
            r_xmin <= abd_pkg::sat_out(w_xmin);
            r_ymax <= abd_pkg::sat_out(w_ymax);
            r_xmax <= abd_pkg::sat_out(w_xmax);
        end
    end

    assign o_rsp.valid    = r_vld[abd_pkg::ST_OUT];
    assign o_rsp.box_ymin = r_ymin;
    assign o_rsp.box_xmin = r_xmin;
    assign o_rsp.box_ymax = r_ymax;
    assign o_rsp.box_xmax = r_xmax;

    `ABD_ASSERT_NXT(a_req_enters_s1, i_req.valid && i_req.ready, r_vld[abd_pkg::ST_MUL], "accepted request not in stage 1")
    `ABD_ASSERT_NXT(a_full_stall_holds, !w_en[abd_pkg::ST_MUL], &r_vld, "full pipeline lost a request while stalled")
    `ABD_ASSERT_IMP(a_corner_order, o_rsp.valid, (o_rsp.box_ymin <= o_rsp.box_ymax) && (o_rsp.box_xmin <= o_rsp.box_xmax), "box corners out of order")

endmodule

>>> sv/abd_exp_half.sv
// Half extent pipeline: clamp, range reduction by ln2, Horner exp, scale.
// Stages ST_CLAMP..ST_HALF; depends on abd_pkg.
module abd_exp_half (
    input  logic               i_clk,
    input  abd_pkg::t_stg_en   i_en,
    input  logic signed [31:0] i_arg,
    input  logic [14:0]        i_size,
    output logic [21:0]        o_half
);

    logic signed [31:0] w_clamp;
    logic [30:0]        n_v;
    logic [30:0]        r_v [abd_pkg::ST_CLAMP:abd_pkg::ST_QUOT];
    logic [62:0]        w_qprod;
    logic [4:0]         r_q [abd_pkg::ST_QUOT:abd_pkg::ST_PROD];
    logic [30:0]        w_rem;
    logic [25:0]        r_r [abd_pkg::ST_REM:abd_pkg::ST_PROD-3];
    logic [14:0]        r_sz [abd_pkg::ST_CLAMP:abd_pkg::ST_PROD-1];
    logic [27:0]        r_x [0:abd_pkg::H_STEPS-1];
    logic [27:0]        r_p [0:abd_pkg::H_STEPS-1];
    logic [42:0]        r_prod;
    logic [5:0]         w_sh;
    logic [42:0]        w_y;
    logic [23:0]        w_y1;
    logic [21:0]        r_half;

    always_comb begin
        if (i_arg < abd_pkg::ARG_MIN) begin
            w_clamp = abd_pkg::ARG_MIN;
        end else if (i_arg > abd_pkg::ARG_MAX) begin
            w_clamp = abd_pkg::ARG_MAX;
        end else begin
            w_clamp = i_arg;
        end
        n_v = 31'(w_clamp + abd_pkg::V_BIAS);
    end

    assign w_qprod = 63'(r_v[abd_pkg::ST_CLAMP]) * 63'(abd_pkg::Q_MAGIC);
    assign w_rem   = r_v[abd_pkg::ST_QUOT] - 31'(r_q[abd_pkg::ST_QUOT]) * abd_pkg::LN2_S;

    always_ff @(posedge i_clk) begin
        if (i_en[abd_pkg::ST_CLAMP]) begin
            r_v[abd_pkg::ST_CLAMP]  <= n_v;
            r_sz[abd_pkg::ST_CLAMP] <= i_size;
        end
        if (i_en[abd_pkg::ST_QUOT]) begin
            r_v[abd_pkg::ST_QUOT] <= r_v[abd_pkg::ST_CLAMP];
            r_q[abd_pkg::ST_QUOT] <= w_qprod[abd_pkg::Q_SHIFT +: 5];
        end
        if (i_en[abd_pkg::ST_REM]) begin
            r_r[abd_pkg::ST_REM] <= w_rem[25:0];
        end
        for (int k = abd_pkg::ST_QUOT + 1; k <= abd_pkg::ST_PROD; k++) begin
            if (i_en[k]) begin
                r_q[k] <= r_q[k-1];
            end
        end
        for (int k = abd_pkg::ST_REM + 1; k <= abd_pkg::ST_PROD - 3; k++) begin
            if (i_en[k]) begin
                r_r[k] <= r_r[k-1];
            end
        end
        for (int k = abd_pkg::ST_CLAMP + 1; k <= abd_pkg::ST_PROD - 1; k++) begin
            if (i_en[k]) begin
                r_sz[k] <= r_sz[k-1];
            end
        end
    end

    // Horner step j divides by n = H_STEPS - j: multiply stage, then divide stage
    for (genvar j = 0; j < abd_pkg::H_STEPS; j++) begin : g_step
        localparam int M = abd_pkg::ST_HORN + 2 * j;
        logic [27:0] w_pin;
        logic [53:0] w_mp;
        logic [59:0] w_dp;

        if (j == 0) begin : g_first
            assign w_pin = abd_pkg::ONE_S;
        end else begin : g_next
            assign w_pin = r_p[j-1];
        end

        assign w_mp = 54'(r_r[M-1]) * 54'(w_pin);
        assign w_dp = 60'(r_x[j]) * 60'(abd_pkg::horner_magic(abd_pkg::H_STEPS - j));

        always_ff @(posedge i_clk) begin
            if (i_en[M]) begin
                r_x[j] <= w_mp[53:26];
            end
            if (i_en[M+1]) begin
                r_p[j] <= abd_pkg::ONE_S + w_dp[58:31];
            end
        end
    end

    assign w_sh = 6'(abd_pkg::HALF_SH_BASE) - 6'(r_q[abd_pkg::ST_PROD]);
    assign w_y  = r_prod >> w_sh;
    assign w_y1 = 24'(w_y[22:0]) + 24'd1;

    always_ff @(posedge i_clk) begin
        if (i_en[abd_pkg::ST_PROD]) begin
            r_prod <= 43'(r_p[abd_pkg::H_STEPS-1]) * 43'(r_sz[abd_pkg::ST_PROD-1]);
        end
        if (i_en[abd_pkg::ST_HALF]) begin
            r_half <= w_y1[22:1];
        end
    end

    assign o_half = r_half;

endmodule

>>> dv/anchor_box_decode_checker.sv
// Checker for the anchor box decoder: predicts a box for every request taken
// and compares it with the result channel. Needs abd_pkg, abd_in_if, abd_out_if.
module anchor_box_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abd_in_if           i_req,
    abd_out_if          i_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_err_cnt,
    output int          o_pending
);

    localparam longint ONE_Q26        = 67108864;
    localparam longint HALF_Q26       = 33554432;
    localparam longint LN2_Q26        = 46516320;
    localparam longint EXP_ARG_LO     = -805306368;
    localparam longint EXP_ARG_HI     = 268435456;
    localparam longint EXP_BIAS_STEPS = 18;

    typedef struct {
        logic signed [19:0] ymin;
        logic signed [19:0] xmin;
        logic signed [19:0] ymax;
        logic signed [19:0] xmax;
    } t_box;

    logic [15:0] y_recip = abd_pkg::Y_RECIP_RST;
    logic [15:0] x_recip = abd_pkg::X_RECIP_RST;
    logic [15:0] h_recip = abd_pkg::H_RECIP_RST;
    logic [15:0] w_recip = abd_pkg::W_RECIP_RST;
    t_box        pending_boxes[$];
    int          boxes_seen;

    // centre in Q.14, rounded to nearest with ties away from zero
    function automatic longint centre_at(input logic signed [15:0] enc,
                                         input logic [15:0] recip,
                                         input logic [14:0] size,
                                         input logic signed [15:0] ctr);
        longint e, g, z, c, prod;
        e = enc;
        g = recip;
        z = size;
        c = ctr;
        prod = e * g * z;
        if (prod >= 0) begin
            return ((prod + HALF_Q26) >>> 26) + c;
        end
        return c - ((HALF_Q26 - prod) >>> 26);
    endfunction

    // half of exp(scaled offset) times size, Q.14, ties up
    function automatic longint half_span(input logic signed [15:0] enc,
                                         input logic [15:0] recip,
                                         input logic [14:0] size);
        longint e, g, z, arg, v, q, r, p, sh;
        int     n;
        e = enc;
        g = recip;
        z = size;
        arg = e * g;
        if (arg < EXP_ARG_LO) arg = EXP_ARG_LO;
        if (arg > EXP_ARG_HI) arg = EXP_ARG_HI;
        v = arg + EXP_BIAS_STEPS * LN2_Q26;
        q = v / LN2_Q26;
        r = v - q * LN2_Q26;
        p = ONE_Q26;
        for (n = 8; n >= 1; n--) begin
            p = ONE_Q26 + ((r * p) >>> 26) / n;
        end
        sh = 27 - (q - EXP_BIAS_STEPS);
        return (p * z + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [19:0] clip_q5_14(input longint v);
        if (v < -524288) return 20'sh80000;
        if (v > 524287) return 20'sh7FFFF;
        return v[19:0];
    endfunction

    function automatic t_box decode_box(input logic signed [15:0] ey, ex, eh, ew, ay, ax,
                                        input logic [14:0] ah, aw);
        longint cy, cx, hh, hw;
        t_box   b;
        cy = centre_at(ey, y_recip, ah, ay);
        cx = centre_at(ex, x_recip, aw, ax);
        hh = half_span(eh, h_recip, ah);
        hw = half_span(ew, w_recip, aw);
        b.ymin = clip_q5_14(cy - hh);
        b.xmin = clip_q5_14(cx - hw);
        b.ymax = clip_q5_14(cy + hh);
        b.xmax = clip_q5_14(cx + hw);
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("anchor_box_decode_checker: %s", msg);
        o_err_cnt++;
    endtask

    task automatic check_corner(input string corner, input logic signed [19:0] got,
                                input logic signed [19:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("box %0d %s: got %0d want %0d",
                                      boxes_seen, corner, got, want));
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_box want;
        if (!i_rst_n) begin
            y_recip <= abd_pkg::Y_RECIP_RST;
            x_recip <= abd_pkg::X_RECIP_RST;
            h_recip <= abd_pkg::H_RECIP_RST;
            w_recip <= abd_pkg::W_RECIP_RST;
        end else begin
            if (i_cfg_we) begin
                case (abd_pkg::t_cfg_idx'(i_cfg_idx))
                    abd_pkg::CFG_Y_RECIP: y_recip <= i_cfg_data;
                    abd_pkg::CFG_X_RECIP: x_recip <= i_cfg_data;
                    abd_pkg::CFG_H_RECIP: h_recip <= i_cfg_data;
                    abd_pkg::CFG_W_RECIP: w_recip <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                pending_boxes.push_back(decode_box(i_req.enc_y, i_req.enc_x, i_req.enc_h,
                                                   i_req.enc_w, i_req.anchor_y,
                                                   i_req.anchor_x, i_req.anchor_h,
                                                   i_req.anchor_w));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_boxes.size() == 0) begin
                    report_mismatch($sformatf("box %0d arrived with no request outstanding",
                                              boxes_seen));
                end else begin
                    want = pending_boxes.pop_front();
                    check_corner("ymin", i_rsp.box_ymin, want.ymin);
                    check_corner("xmin", i_rsp.box_xmin, want.xmin);
                    check_corner("ymax", i_rsp.box_ymax, want.ymax);
                    check_corner("xmax", i_rsp.box_xmax, want.xmax);
                end
                boxes_seen++;
            end
        end
        o_pending = pending_boxes.size();
    end

endmodule

>>> dv/anchor_box_decode_top_test.sv
// Testbench top for the anchor box decoder: reset, register settings, directed
// and random requests with random stalls on both sides, and the verdict.
// Needs abd_pkg, the channel interfaces, anchor_box_decode_top and the checker.
module anchor_box_decode_top_test;

    localparam int CLK_PERIOD   = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [15:0] i_cfg_data = '0;
    logic        steady     = 1'b0;
    int          err_cnt;
    int          boxes_owed;

    abd_in_if  req_if ();
    abd_out_if rsp_if ();

    anchor_box_decode_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    anchor_box_decode_checker box_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .i_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_err_cnt  (err_cnt),
        .o_pending  (boxes_owed)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= 32);
        end
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("anchor_box_decode_top_test: FAIL");
        $finish;
    end

    task automatic send_anchor(input logic signed [15:0] ey, ex, eh, ew, ay, ax,
                               input logic [14:0] ah, aw);
        while (!steady && ($urandom_range(99) < 32)) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.enc_y    <= ey;
        req_if.enc_x    <= ex;
        req_if.enc_h    <= eh;
        req_if.enc_w    <= ew;
        req_if.anchor_y <= ay;
        req_if.anchor_x <= ax;
        req_if.anchor_h <= ah;
        req_if.anchor_w <= aw;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // mostly offsets within +-2.0 and anchors in the unit square, some full range
    function automatic logic signed [15:0] rand_offset();
        if ($urandom_range(99) < 65) return 16'($urandom_range(16383) - 8192);
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] rand_centre();
        if ($urandom_range(99) < 65) return 16'($urandom_range(16384));
        return 16'($urandom);
    endfunction

    function automatic logic [14:0] rand_size();
        if ($urandom_range(99) < 65) return 15'($urandom_range(16384));
        return 15'($urandom);
    endfunction

    function automatic logic [15:0] rand_recip();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(8192));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int n);
        repeat (n) begin
            send_anchor(rand_offset(), rand_offset(), rand_offset(), rand_offset(),
                        rand_centre(), rand_centre(), rand_size(), rand_size());
        end
    endtask

    // stop sending and wait for every outstanding box
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (boxes_owed != 0);
        @(posedge i_clk);
    endtask

    task automatic program_recips(input logic [15:0] y, x, h, w);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= abd_pkg::CFG_Y_RECIP;
        i_cfg_data <= y;
        @(posedge i_clk);
        i_cfg_idx  <= abd_pkg::CFG_X_RECIP;
        i_cfg_data <= x;
        @(posedge i_clk);
        i_cfg_idx  <= abd_pkg::CFG_H_RECIP;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_idx  <= abd_pkg::CFG_W_RECIP;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        req_if.valid    = 1'b0;
        req_if.enc_y    = '0;
        req_if.enc_x    = '0;
        req_if.enc_h    = '0;
        req_if.enc_w    = '0;
        req_if.anchor_y = '0;
        req_if.anchor_x = '0;
        req_if.anchor_h = '0;
        req_if.anchor_w = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset reciprocals
        send_anchor(0, 0, 0, 0, 0, 0, 0, 0);
        send_anchor(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                    16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF);
        send_anchor(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                    16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF);
        send_anchor(4096, 4096, 4096, 4096, 8192, 8192, 16384, 16384);
        send_anchor(-4096, 4096, -4096, 4096, 8192, -8192, 0, 0);
        send_anchor(0, 0, 16'sh7FFF, 16'sh8000, 0, 0, 15'h7FFF, 15'h7FFF);
        send_random(300);
        settle();

        // full-scale reciprocals: exp argument clamps at both ends
        program_recips(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_anchor(0, 0, 16'sh7FFF, 16'sh7FFF, 0, 0, 15'h7FFF, 15'h7FFF);
        send_anchor(0, 0, 16'sh8000, 16'sh8000, 0, 0, 15'h7FFF, 15'h7FFF);
        send_anchor(16'sh7FFF, 16'sh7FFF, 0, 0, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF);
        send_anchor(16'sh8000, 16'sh8000, 0, 0, 16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF);
        send_random(300);
        settle();

        // zero reciprocals: offsets drop out, exp gives one
        program_recips(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_anchor(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8192, 8192, 16384, 16384);
        send_anchor(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, -8192, 8192, 15'h7FFF, 1);
        send_random(200);
        settle();

        repeat (4) begin
            program_recips(rand_recip(), rand_recip(), rand_recip(), rand_recip());
            send_random(100);
            settle();
        end

        // unit reciprocals: rounding ties on the centre, exp(0) on odd sizes
        program_recips(16'd16384, 16'd16384, 16'd16384, 16'd16384);
        send_anchor(1, -1, 0, 0, 0, 0, 2048, 2048);
        send_anchor(-1, 1, 0, 0, 0, 0, 1, 3);
        steady <= 1'b1;
        send_random(300);
        settle();
        steady <= 1'b0;

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_cnt == 0 && boxes_owed == 0) begin
            $display("anchor_box_decode_top_test: PASS");
        end else begin
            $display("anchor_box_decode_top_test: FAIL");
        end
        $finish;
    end

endmodule

>>> anchor_box_decode_top.f
+incdir+sv
sv/abd_pkg.sv
sv/abd_in_if.sv
sv/abd_out_if.sv
sv/abd_exp_half.sv
sv/anchor_box_decode_top.sv
dv/anchor_box_decode_checker.sv
dv/anchor_box_decode_top_test.sv
